// ===== rtl/swmm_pkg.sv =====
// swmm_pkg: shared constants for the sliding-window min/max block.
// Has no dependencies. Used by sliding_window_min_max_top.
package swmm_pkg;

	localparam int MAX_WINDOW_DEFAULT = 128;

	localparam int SAMPLE_W  = 32;
	localparam int WINDOW_W  = 8;
	localparam int COUNT_W   = 8;

	localparam logic [WINDOW_W-1:0] WINDOW_RESET = 8'd100;

	localparam logic FUNC_ADD   = 1'b0;
	localparam logic FUNC_CLEAR = 1'b1;

endpackage

// ===== rtl/sliding_window_min_max_top.sv =====
// sliding_window_min_max_top: sample ring in a synchronous memory, rescanned
// one entry per cycle for minimum and maximum. Depends on swmm_pkg.
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+----------------------------------
//  in      | in        | in_valid / in_stall   | func, sample
//  out     | out       | out_valid / out_stall | window_min, window_max, stored_count
//  cfg     | in        | cfg_wr_en             | cfg_wr_data (window_length)
//
// Steps: an add passes from transfer to result through a write state, the scan
//   reads of the held entries, the memory read register, a check that the scan
//   has finished, and the load of the output register. The single memory read
//   port makes the scan read one entry at a time. A clear goes from the write
//   state straight to the load of the output register.
// One item is in work at a time; in_stall is high from transfer until the
//   result is loaded into the output register.
// A result held by out_stall does not block the next transfer in; only the
//   load of the following result waits for it.
// Reset clears control, count, ring position and extremes; the ring memory
//   itself is not cleared (only written entries are ever read).
module sliding_window_min_max_top #(
	parameter int MAX_WINDOW = swmm_pkg::MAX_WINDOW_DEFAULT
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// input channel
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic                                 func,
	input  logic signed [swmm_pkg::SAMPLE_W-1:0] sample,
	// output channel
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic signed [swmm_pkg::SAMPLE_W-1:0] window_min,
	output logic signed [swmm_pkg::SAMPLE_W-1:0] window_max,
	output logic        [swmm_pkg::COUNT_W-1:0]  stored_count,
	// window length register
	input  logic                                 cfg_wr_en,
	input  logic        [swmm_pkg::WINDOW_W-1:0] cfg_wr_data
);

	// ring holds one spare entry: the new sample goes in before the oldest drops
	localparam int DEPTH = MAX_WINDOW + 1;
	localparam int AW    = $clog2(DEPTH);
	localparam int CW    = $clog2(MAX_WINDOW + 1);
	// compare width: fits held + 1, the window register and MAX_WINDOW
	localparam int CMPW  = ((CW > swmm_pkg::WINDOW_W) ? CW : swmm_pkg::WINDOW_W) + 1;
	localparam int SW    = swmm_pkg::SAMPLE_W;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_WR   = 2'd1;
	localparam logic [1:0] ST_SCAN = 2'd2;
	localparam logic [1:0] ST_DONE = 2'd3;

	logic [1:0]                   state_q;
	logic                         func_q;
	logic signed [SW-1:0]         sample_q;
	logic [swmm_pkg::WINDOW_W-1:0] win_q;
	logic [AW-1:0]                oldest_q;
	logic [CW-1:0]                held_q;
	logic signed [SW-1:0]         min_q;
	logic signed [SW-1:0]         max_q;
	logic [AW-1:0]                rd_ptr_q;
	logic [CW-1:0]                rd_cnt_q;
	logic                         rd_vld_s1;
	logic signed [SW-1:0]         rd_data_s1;
	logic                         out_valid_q;
	logic signed [SW-1:0]         out_min_q;
	logic signed [SW-1:0]         out_max_q;
	logic [swmm_pkg::COUNT_W-1:0] out_count_q;

	logic [SW-1:0]                ring_mem [DEPTH];

	logic                         in_xfer;
	logic                         out_xfer;
	logic                         mem_we;
	logic [AW:0]                  wr_sum;
	logic [AW-1:0]                wr_addr;
	logic [AW-1:0]                oldest_next;
	logic [CMPW-1:0]              held_inc;
	logic [CMPW-1:0]              limit;
	logic                         drop_oldest;

	assign in_stall = (state_q != ST_IDLE);
	assign in_xfer  = in_valid && !in_stall;
	assign out_xfer = out_valid_q && !out_stall;

	// effective window: register saturated at the ring's usable depth
	assign limit = (CMPW'(win_q) > CMPW'(MAX_WINDOW)) ? CMPW'(MAX_WINDOW) : CMPW'(win_q);

	// write slot = oldest + held, wrapped once (both below DEPTH)
	assign wr_sum  = (AW+1)'(oldest_q) + (AW+1)'(held_q);
	assign wr_addr = (wr_sum >= (AW+1)'(DEPTH)) ? AW'(wr_sum - (AW+1)'(DEPTH))
	                                            : AW'(wr_sum);

	assign held_inc    = CMPW'(held_q) + CMPW'(1);
	assign drop_oldest = (held_inc > limit);
	assign oldest_next = (oldest_q == AW'(DEPTH - 1)) ? '0 : oldest_q + AW'(1);

	assign mem_we = (state_q == ST_WR) && (func_q == swmm_pkg::FUNC_ADD);

	// Ring memory: written in ST_WR; reads are taken up only when issued in
	// ST_SCAN, so a used read never meets a write to the same entry in one cycle.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			ring_mem[wr_addr] <= sample_q;
		end
		rd_data_s1 <= ring_mem[rd_ptr_q];
	end

	// item payload capture
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			func_q   <= func;
			sample_q <= sample;
		end
	end

	// window length register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q <= swmm_pkg::WINDOW_RESET;
		end else if (cfg_wr_en) begin
			win_q <= cfg_wr_data;
		end
	end

	// sequencer, ring pointers and running extremes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			oldest_q  <= '0;
			held_q    <= '0;
			min_q     <= '0;
			max_q     <= '0;
			rd_ptr_q  <= '0;
			rd_cnt_q  <= '0;
			rd_vld_s1 <= 1'b0;
		end else begin
			rd_vld_s1 <= 1'b0;

			// fold in a sample returned by the memory
			if (rd_vld_s1) begin
				if (rd_data_s1 < min_q) begin
					min_q <= rd_data_s1;
				end
				if (rd_data_s1 > max_q) begin
					max_q <= rd_data_s1;
				end
			end

			case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						state_q <= ST_WR;
					end
				end
				ST_WR: begin
					if (func_q == swmm_pkg::FUNC_CLEAR) begin
						held_q   <= '0;
						oldest_q <= '0;
						state_q  <= ST_DONE;
					end else begin
						// new sample seeds both extremes
						min_q    <= sample_q;
						max_q    <= sample_q;
						rd_cnt_q <= '0;
						if (drop_oldest) begin
							oldest_q <= oldest_next;
							rd_ptr_q <= oldest_next;
						end else begin
							held_q   <= CW'(held_inc);
							rd_ptr_q <= oldest_q;
						end
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (rd_cnt_q != held_q) begin
						rd_vld_s1 <= 1'b1;
						rd_cnt_q  <= rd_cnt_q + CW'(1);
						rd_ptr_q  <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
					end else if (!rd_vld_s1) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (!out_valid_q || !out_stall) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((state_q == ST_DONE) && (!out_valid_q || !out_stall)) begin
			out_valid_q <= 1'b1;
		end else if (out_xfer) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_DONE) && (!out_valid_q || !out_stall)) begin
			out_min_q   <= min_q;
			out_max_q   <= max_q;
			out_count_q <= swmm_pkg::COUNT_W'(held_q);
		end
	end

	assign out_valid    = out_valid_q;
	assign window_min   = out_min_q;
	assign window_max   = out_max_q;
	assign stored_count = out_count_q;

`ifndef SYNTHESIS
	a_held_bound: assert property (@(posedge clk) disable iff (!arst_n)
		CMPW'(held_q) <= CMPW'(MAX_WINDOW))
		else $error("held count above ring capacity");

	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> (rd_cnt_q <= held_q))
		else $error("scan counter ran past held count");

	a_read_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		rd_vld_s1 |-> ($past(state_q) == ST_SCAN))
		else $error("memory read returned outside scan");

	a_load_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> ($past(state_q) == ST_DONE))
		else $error("result loaded without finished item");

	a_no_write_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> !mem_we)
		else $error("ring written during scan");
`endif

endmodule

// ===== test/sliding_window_min_max_top_tb.sv =====
// Testbench for sliding_window_min_max_top: random and directed add/clear items,
// checked against an in-bench model of the sample window. Depends on swmm_pkg and the RTL.
`timescale 1ns / 100ps

module sliding_window_min_max_top_tb;

	localparam int MAX_WINDOW = swmm_pkg::MAX_WINDOW_DEFAULT;
	localparam int SAMPLE_W = swmm_pkg::SAMPLE_W;
	localparam int COUNT_W = swmm_pkg::COUNT_W;
	localparam int WINDOW_W = swmm_pkg::WINDOW_W;
	localparam int RING_DEPTH = MAX_WINDOW + 1;
	localparam int HOLD_CYCLES = 400;
	localparam int PHASES = 12;
	localparam int PHASE_ITEMS = 135;

	typedef struct packed {
		logic                       fn;
		logic signed [SAMPLE_W-1:0] smp;
	} window_item_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] lo;
		logic signed [SAMPLE_W-1:0] hi;
		logic [COUNT_W-1:0]         cnt;
	} window_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic func = swmm_pkg::FUNC_ADD;
	logic signed [SAMPLE_W-1:0] sample = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [SAMPLE_W-1:0] window_min;
	logic signed [SAMPLE_W-1:0] window_max;
	logic [COUNT_W-1:0] stored_count;
	logic cfg_wr_en = 1'b0;
	logic [WINDOW_W-1:0] cfg_wr_data = '0;

	sliding_window_min_max_top #(
		.MAX_WINDOW(MAX_WINDOW)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.func(func),
		.sample(sample),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.window_min(window_min),
		.window_max(window_max),
		.stored_count(stored_count),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data)
	);

	// Model of the window: ring, position of the oldest sample, count and extremes
	logic signed [SAMPLE_W-1:0] ring_copy [RING_DEPTH];
	int                         oldest_pos = 0;
	int                         held = 0;
	logic signed [SAMPLE_W-1:0] last_min = '0;
	logic signed [SAMPLE_W-1:0] last_max = '0;
	logic [WINDOW_W-1:0]        window_len = swmm_pkg::WINDOW_RESET;

	window_item_t   pending [$];   // items waiting for the driver
	window_result_t due_extremes [$];   // predicted results, oldest first
	window_item_t   next_item;
	window_result_t seen;
	window_result_t want;

	int  mismatches;
	bit  in_taken;
	int  send_gap;
	int  recv_gap;
	int  hold_left;
	bit  hold_req;
	bit  hold_done;
	bit  send_idle_on;
	bit  recv_idle_on;

	initial begin
		forever #6 clk = ~clk;
	end

	// Generous limit: ~1650 items, each at its worst-case scan plus both sides' gaps,
	// the long hold-off, all taken several times over
	initial begin
		#20_000_000;
		$display("Some tests failed");
		$finish;
	end

	task automatic flag_mismatch(input string what, input window_result_t got,
			input window_result_t exp_res);
		mismatches++;
		$display("%0t %s: got min %0d max %0d count %0d, wanted min %0d max %0d count %0d",
			$realtime, what, got.lo, got.hi, got.cnt, exp_res.lo, exp_res.hi, exp_res.cnt);
	endtask

	// One step of the window: add appends and drops at most one oldest sample,
	// clear empties the ring and keeps the last extremes
	task automatic advance_window(input logic fn, input logic signed [SAMPLE_W-1:0] s);
		window_result_t r;
		int lim;
		int k;
		logic signed [SAMPLE_W-1:0] v;
		logic signed [SAMPLE_W-1:0] lo;
		logic signed [SAMPLE_W-1:0] hi;
		if (fn == swmm_pkg::FUNC_CLEAR) begin
			held = 0;
			oldest_pos = 0;
		end else begin
			lim = (int'(window_len) > MAX_WINDOW) ? MAX_WINDOW : int'(window_len);
			ring_copy[(oldest_pos + held) % RING_DEPTH] = s;
			held++;
			if (held > lim) begin
				oldest_pos = (oldest_pos + 1) % RING_DEPTH;
				held--;
			end
			lo = s;
			hi = s;
			for (k = 0; k < held; k++) begin
				v = ring_copy[(oldest_pos + k) % RING_DEPTH];
				if (v < lo)
					lo = v;
				if (v > hi)
					hi = v;
			end
			last_min = lo;
			last_max = hi;
		end
		r.lo = last_min;
		r.hi = last_max;
		r.cnt = COUNT_W'(held);
		due_extremes.push_back(r);
	endtask

	// Input side: note each transfer and predict its result at the same edge
	always @(posedge clk) begin
		in_taken = arst_n && in_valid && !in_stall;
		if (in_taken)
			advance_window(func, sample);
	end

	// Driver: new payload only after a transfer or while idle; stalled payload holds
	always @(negedge clk) begin
		if (!in_valid || in_taken) begin
			if (send_gap > 0) begin
				send_gap--;
				in_valid <= 1'b0;
			end else if (send_idle_on && $urandom_range(0, 5) == 0) begin
				send_gap = $urandom_range(1, 16) - 1;
				in_valid <= 1'b0;
			end else if (pending.size() > 0) begin
				next_item = pending.pop_front();
				in_valid <= 1'b1;
				func <= next_item.fn;
				sample <= next_item.smp;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Receiver: one long hold-off on request, otherwise random stall bursts
	always @(negedge clk) begin
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else if (hold_req && !hold_done) begin
			hold_done = 1'b1;
			hold_left = HOLD_CYCLES - 1;
			out_stall <= 1'b1;
		end else if (recv_gap > 0) begin
			recv_gap--;
			out_stall <= 1'b1;
		end else if (recv_idle_on && $urandom_range(0, 5) == 0) begin
			recv_gap = $urandom_range(1, 16) - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	// Monitor: each result transfer against the oldest prediction
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			seen.lo = window_min;
			seen.hi = window_max;
			seen.cnt = stored_count;
			if (due_extremes.size() == 0) begin
				flag_mismatch("unexpected result", seen, '0);
			end else begin
				want = due_extremes.pop_front();
				if (seen !== want)
					flag_mismatch("wrong result", seen, want);
			end
		end
	end

	task automatic queue_item(input logic fn, input logic signed [SAMPLE_W-1:0] s);
		window_item_t it;
		it.fn = fn;
		it.smp = s;
		pending.push_back(it);
	endtask

	// Idle means nothing queued, nothing offered and every result back
	task automatic wait_drained();
		while (pending.size() != 0 || due_extremes.size() != 0 || in_valid)
			@(posedge clk);
	endtask

	task automatic set_window(input logic [WINDOW_W-1:0] v);
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		window_len = v;
	endtask

	// Full-range values, a narrow band around zero (many ties) and the extremes
	function automatic logic signed [SAMPLE_W-1:0] pick_sample(input int style);
		logic signed [SAMPLE_W-1:0] s;
		case (style)
			0: s = $urandom_range(0, 15) - 8;
			1: begin
				case ($urandom_range(0, 3))
					0: s = 32'sh7FFF_FFFF;
					1: s = 32'sh8000_0000;
					2: s = 32'sd0;
					default: s = -32'sd1;
				endcase
			end
			default: s = $urandom;
		endcase
		return s;
	endfunction

	function automatic logic [WINDOW_W-1:0] random_window();
		int pick;
		pick = $urandom_range(0, 9);
		if (pick < 5)
			return WINDOW_W'($urandom_range(1, 16));
		else if (pick < 8)
			return WINDOW_W'($urandom_range(17, 127));
		else
			return WINDOW_W'($urandom_range(128, 255));
	endfunction

	logic [WINDOW_W-1:0] wl;
	int ph;
	int i;
	int clear_div;

	initial begin
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: extremes at the reset window, clears, repeated clear
		queue_item(swmm_pkg::FUNC_ADD, 32'sh7FFF_FFFF);
		queue_item(swmm_pkg::FUNC_ADD, 32'sh8000_0000);
		queue_item(swmm_pkg::FUNC_ADD, 32'sd0);
		queue_item(swmm_pkg::FUNC_ADD, -32'sd1);
		queue_item(swmm_pkg::FUNC_ADD, 32'sd1);
		queue_item(swmm_pkg::FUNC_CLEAR, 32'sh5A5A_A5A5);
		queue_item(swmm_pkg::FUNC_ADD, 32'sh1234_5678);
		queue_item(swmm_pkg::FUNC_CLEAR, 32'sd0);
		queue_item(swmm_pkg::FUNC_CLEAR, -32'sd1);
		wait_drained();

		// Window of zero: each add leaves the ring empty
		set_window('0);
		queue_item(swmm_pkg::FUNC_ADD, 32'sd5);
		queue_item(swmm_pkg::FUNC_ADD, -32'sd7);
		queue_item(swmm_pkg::FUNC_ADD, 32'sh8000_0000);
		wait_drained();

		set_window(8'd2);
		queue_item(swmm_pkg::FUNC_ADD, 32'sd3);
		queue_item(swmm_pkg::FUNC_ADD, 32'sh7FFF_FFFF);
		queue_item(swmm_pkg::FUNC_ADD, -32'sd3);
		queue_item(swmm_pkg::FUNC_ADD, 32'sd0);
		wait_drained();

		set_window(8'd1);
		queue_item(swmm_pkg::FUNC_ADD, 32'sd9);
		queue_item(swmm_pkg::FUNC_ADD, -32'sd9);
		queue_item(swmm_pkg::FUNC_CLEAR, 32'sd0);
		wait_drained();

		// Random phases: fill at full depth, shrink under a long hold-off,
		// window above depth, zero and one, then random settings; the last phase runs flat out
		for (ph = 0; ph < PHASES; ph++) begin
			case (ph)
				0: wl = 8'd128;
				1: wl = 8'd3;
				2: wl = 8'd255;
				3: wl = 8'd129;
				4: wl = 8'd0;
				5: wl = 8'd1;
				default: wl = random_window();
			endcase
			set_window(wl);
			send_idle_on = (ph != PHASES - 1) && ($urandom_range(0, 3) != 0);
			recv_idle_on = (ph != PHASES - 1) && ($urandom_range(0, 3) != 0);
			if (ph == 1)
				hold_req = 1'b1;
			// no clears while filling, so the shrink starts from a full ring
			clear_div = (ph < 4) ? 0 : 16;
			for (i = 0; i < PHASE_ITEMS; i++) begin
				if (clear_div != 0 && $urandom_range(1, clear_div) == 1)
					queue_item(swmm_pkg::FUNC_CLEAR, $urandom);
				else
					queue_item(swmm_pkg::FUNC_ADD, pick_sample($urandom_range(0, 3)));
			end
			wait_drained();
		end

		// Let any stray result show up before the verdict
		repeat (140) @(negedge clk);
		if (mismatches == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

// ===== sliding_window_min_max_top.f =====
rtl/swmm_pkg.sv
rtl/sliding_window_min_max_top.sv
test/sliding_window_min_max_top_tb.sv
